// ===== src/cfa_pkg.sv =====
package cfa_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_MODES  = 64;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SAMP_W     = 16;
  localparam int SUM_W      = SAMP_W + PT_AW;
  localparam int MODE_W     = 6;
  localparam int QW_BITS    = 10;
  localparam int QW_SIZE    = 1 << QW_BITS;
  localparam int QW_AW      = QW_BITS + 1;
  localparam int MUL_W      = SUM_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = PROD_W;
  localparam int DIV_NUM_W  = ACC_W;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
  localparam int COEF_W     = 32;

  localparam logic CFG_HIGHEST_MODE = 1'b0;
  localparam logic CFG_NORMALIZE    = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [15:0] qwave_t [0:QW_SIZE];

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  // shift and subtract quotient, numerator stays below 2^40
  function automatic longint unsigned shift_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 39; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter-wave sine table, Q30 taylor series
  function automatic qwave_t build_qwave();
    qwave_t           t;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint           acc;
    longint unsigned  v;
    for (int k = 0; k <= QW_SIZE; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >> QW_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        term = shift_div((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = (longint'(acc) + 64'd8192) >> 14;
      if (v > 64'd65535) v = 64'd65535;
      t[k] = v[15:0];
    end
    return t;
  endfunction

endpackage

// ===== src/contour_fourier_amplitudes_core.sv =====
// Contour Fourier amplitudes. Radius words stream in at one per cycle while
// in_ready is high and are stored (up to MAX_POINTS, extras dropped) with
// their running sum. The word flagged last closes the contour: in_ready then
// falls and the block emits one coefficient pair per mode q = 0..highest_mode,
// ascending. Per contour the mean takes one pass of the shared restoring
// divider and the denominator one use of the single multiplier; each mode then
// takes four divider passes (two when the zero-mean flag is raised) and, for
// each stored sample, the states ST_SA, ST_SB, ST_SC and ST_SD through the
// single multiplier and the registered sample and sine table reads, plus the
// wait for out_ready. Configuration must be written only while idle.
module contour_fourier_amplitudes_core import cfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [MODE_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMP_W-1:0]        in_radius_sample,
  input  logic                     in_last_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MODE_W-1:0]        out_mode_number,
  output logic signed [COEF_W-1:0] out_cosine_coeff,
  output logic signed [COEF_W-1:0] out_sine_coeff,
  output logic [SAMP_W-1:0]        out_mean_radius,
  output logic                     out_zero_mean_flag,
  output logic                     out_last_result
);

  typedef enum logic [12:0] {
    ST_LOAD    = 13'b0000000000001,
    ST_MEAN_W  = 13'b0000000000010,
    ST_DEN     = 13'b0000000000100,
    ST_STEP_W  = 13'b0000000001000,
    ST_STEPQ_W = 13'b0000000010000,
    ST_SA      = 13'b0000000100000,
    ST_SB      = 13'b0000001000000,
    ST_SC      = 13'b0000010000000,
    ST_SD      = 13'b0000100000000,
    ST_FIN     = 13'b0001000000000,
    ST_DA_W    = 13'b0010000000000,
    ST_DB_W    = 13'b0100000000000,
    ST_EMIT    = 13'b1000000000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [MODE_W-1:0]         hmode_r, hmode_nxt;
  logic                      norm_r, norm_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [SUM_W-1:0]          s_r, s_nxt;
  logic [SAMP_W-1:0]         mean_r, mean_nxt;
  logic [DIV_DEN_W-1:0]      den_r, den_nxt;
  logic                      zflag_r, zflag_nxt;
  logic [MODE_W-1:0]         q_r, q_nxt;
  logic [PT_AW-1:0]          stepr_r, stepr_nxt;
  logic [15:0]               stepq_r, stepq_nxt;
  logic [15:0]               phase_r, phase_nxt;
  logic [PT_AW-1:0]          prem_r, prem_nxt;
  logic [PT_AW-1:0]          i_r, i_nxt;
  logic signed [MUL_W-1:0]   d_r, d_nxt;
  logic signed [16:0]        trig_r, trig_nxt;
  logic signed [ACC_W-1:0]   accs_r, accs_nxt;
  logic signed [ACC_W-1:0]   accc_r, accc_nxt;
  logic signed [COEF_W-1:0]  a_r, a_nxt;
  logic signed [COEF_W-1:0]  b_r, b_nxt;
  div_req_t                  req_r, req_nxt;
  div_rsp_t                  rsp;

  logic                      accept;
  logic                      room;
  logic                      ram_we;
  logic [SAMP_W-1:0]         ram_q;
  logic [QW_AW-1:0]          rom_addr;
  logic [15:0]               rom_q;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [11:0]               idx_s, idx_c;
  logic [16:0]               phase_rnd;
  logic [PT_AW:0]            prem_sum;
  logic [MODE_W-1:0]         qmax;
  logic signed [16:0]        rom_s;
  logic [ACC_W-1:0]          mag_c, mag_s;

  function automatic logic [QW_AW-1:0] qaddr(input logic [11:0] idx);
    logic [QW_AW-1:0] k;
    k = {1'b0, idx[QW_BITS-1:0]};
    return idx[QW_BITS] ? (QW_AW'(QW_SIZE) - k) : k;
  endfunction

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  function automatic logic [COEF_W-1:0] sat(input logic neg,
                                            input logic [DIV_NUM_W-1:0] quo);
    logic [COEF_W-1:0] r;
    if (neg) begin
      if (quo > DIV_NUM_W'(64'h80000000)) r = 32'h80000000;
      else r = ~quo[COEF_W-1:0] + 1'b1;
    end else begin
      if (quo > DIV_NUM_W'(64'h7fffffff)) r = 32'h7fffffff;
      else r = quo[COEF_W-1:0];
    end
    return r;
  endfunction

  assign in_ready  = (state_r == ST_LOAD);
  assign accept    = in_valid && in_ready;
  assign room      = (cnt_r < CNT_W'(MAX_POINTS));
  assign ram_we    = accept && room;
  assign qmax      = (hmode_r > MODE_W'(MAX_MODES - 1)) ? MODE_W'(MAX_MODES - 1) : hmode_r;
  assign phase_rnd = {1'b0, phase_r} + 17'd8;
  assign idx_s     = phase_rnd[15:4];
  assign idx_c     = idx_s + 12'(QW_SIZE);
  assign prem_sum  = {1'b0, prem_r} + {1'b0, stepr_r};
  assign mag_c     = mag(accc_r) + ACC_W'(den_r >> 1);
  assign mag_s     = mag(accs_r) + ACC_W'(den_r >> 1);
  assign rom_s     = $signed({1'b0, rom_q});

  cfa_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[PT_AW-1:0]),
    .wdata (in_radius_sample),
    .raddr (i_r),
    .rdata (ram_q)
  );

  cfa_qrom u_qrom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  cfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_comb begin
    rom_addr = qaddr(idx_s);
    mul_a    = MUL_W'($signed({1'b0, n_r}));
    mul_b    = MUL_W'($signed({1'b0, ram_q}));
    case (state_r)
      ST_DEN: begin
        mul_b = norm_r ? MUL_W'($signed({1'b0, s_r})) : MUL_W'($signed({1'b0, n_r}));
      end
      ST_SB: begin
        rom_addr = qaddr(idx_c);
      end
      ST_SC, ST_SD: begin
        mul_a = d_r;
        mul_b = MUL_W'(trig_r);
      end
      default: begin
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    state_nxt = state_r;
    hmode_nxt = hmode_r;
    norm_nxt  = norm_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    n_nxt     = n_r;
    s_nxt     = s_r;
    mean_nxt  = mean_r;
    den_nxt   = den_r;
    zflag_nxt = zflag_r;
    q_nxt     = q_r;
    stepr_nxt = stepr_r;
    stepq_nxt = stepq_r;
    phase_nxt = phase_r;
    prem_nxt  = prem_r;
    i_nxt     = i_r;
    d_nxt     = d_r;
    trig_nxt  = trig_r;
    accs_nxt  = accs_r;
    accc_nxt  = accc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    req_nxt   = req_r;
    req_nxt.start = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_HIGHEST_MODE: hmode_nxt = cfg_wdata;
        CFG_NORMALIZE:    norm_nxt  = cfg_wdata[0];
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            cnt_nxt = cnt_r + 1'b1;
            sum_nxt = sum_r + SUM_W'(in_radius_sample);
          end
          if (in_last_sample) begin
            n_nxt         = cnt_nxt;
            s_nxt         = sum_nxt;
            zflag_nxt     = norm_r && (sum_nxt == '0);
            cnt_nxt       = '0;
            sum_nxt       = '0;
            req_nxt.start = 1'b1;
            req_nxt.num   = DIV_NUM_W'(s_nxt) + DIV_NUM_W'(n_nxt >> 1);
            req_nxt.den   = DIV_DEN_W'(n_nxt);
            state_nxt     = ST_MEAN_W;
          end
        end
      end
      ST_MEAN_W: begin
        if (rsp.done) begin
          mean_nxt  = (rsp.quo > DIV_NUM_W'(16'hffff)) ? 16'hffff : rsp.quo[SAMP_W-1:0];
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        den_nxt       = norm_r ? prod[DIV_DEN_W-1:0] : {prod[DIV_DEN_W-9:0], 8'd0};
        q_nxt         = '0;
        req_nxt.start = 1'b1;
        req_nxt.num   = '0;
        req_nxt.den   = DIV_DEN_W'(n_r);
        state_nxt     = ST_STEP_W;
      end
      ST_STEP_W: begin
        if (rsp.done) begin
          req_nxt.start = 1'b1;
          req_nxt.num   = DIV_NUM_W'({rsp.rem[PT_AW-1:0], 16'd0});
          req_nxt.den   = DIV_DEN_W'(n_r);
          state_nxt     = ST_STEPQ_W;
        end
      end
      ST_STEPQ_W: begin
        if (rsp.done) begin
          stepq_nxt = rsp.quo[15:0];
          stepr_nxt = rsp.rem[PT_AW-1:0];
          phase_nxt = '0;
          prem_nxt  = '0;
          i_nxt     = '0;
          accs_nxt  = '0;
          accc_nxt  = '0;
          state_nxt = ST_SA;
        end
      end
      ST_SA: begin
        state_nxt = ST_SB;
      end
      ST_SB: begin
        d_nxt     = prod[MUL_W-1:0] - $signed({1'b0, s_r});
        trig_nxt  = idx_s[11] ? -rom_s : rom_s;
        state_nxt = ST_SC;
      end
      ST_SC: begin
        accs_nxt  = accs_r + prod;
        trig_nxt  = idx_c[11] ? -rom_s : rom_s;
        state_nxt = ST_SD;
      end
      ST_SD: begin
        accc_nxt  = accc_r + prod;
        phase_nxt = phase_r + stepq_r;
        prem_nxt  = prem_sum[PT_AW-1:0];
        if (prem_sum >= n_r) begin
          prem_nxt  = PT_AW'(prem_sum - n_r);
          phase_nxt = phase_r + stepq_r + 16'd1;
        end
        i_nxt = i_r + 1'b1;
        if (CNT_W'(i_r) == n_r - 1'b1) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SA;
        end
      end
      ST_FIN: begin
        if (zflag_r) begin
          a_nxt     = '0;
          b_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          req_nxt.start = 1'b1;
          req_nxt.num   = mag_c;
          req_nxt.den   = den_r;
          state_nxt     = ST_DA_W;
        end
      end
      ST_DA_W: begin
        if (rsp.done) begin
          a_nxt         = sat(accc_r[ACC_W-1], rsp.quo);
          req_nxt.start = 1'b1;
          req_nxt.num   = mag_s;
          req_nxt.den   = den_r;
          state_nxt     = ST_DB_W;
        end
      end
      ST_DB_W: begin
        if (rsp.done) begin
          b_nxt     = sat(accs_r[ACC_W-1], rsp.quo);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (q_r == qmax) begin
            state_nxt = ST_LOAD;
          end else begin
            q_nxt         = q_r + 1'b1;
            req_nxt.start = 1'b1;
            req_nxt.num   = DIV_NUM_W'(q_nxt);
            req_nxt.den   = DIV_DEN_W'(n_r);
            state_nxt     = ST_STEP_W;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_LOAD;
      hmode_r       <= MODE_W'(15);
      norm_r        <= 1'b0;
      cnt_r         <= '0;
      sum_r         <= '0;
      req_r.start   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      hmode_r       <= hmode_nxt;
      norm_r        <= norm_nxt;
      cnt_r         <= cnt_nxt;
      sum_r         <= sum_nxt;
      req_r.start   <= req_nxt.start;
    end
    req_r.num <= req_nxt.num;
    req_r.den <= req_nxt.den;
    n_r       <= n_nxt;
    s_r       <= s_nxt;
    mean_r    <= mean_nxt;
    den_r     <= den_nxt;
    zflag_r   <= zflag_nxt;
    q_r       <= q_nxt;
    stepr_r   <= stepr_nxt;
    stepq_r   <= stepq_nxt;
    phase_r   <= phase_nxt;
    prem_r    <= prem_nxt;
    i_r       <= i_nxt;
    d_r       <= d_nxt;
    trig_r    <= trig_nxt;
    accs_r    <= accs_nxt;
    accc_r    <= accc_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
  end

  assign out_valid          = (state_r == ST_EMIT);
  assign out_mode_number    = q_r;
  assign out_cosine_coeff   = a_r;
  assign out_sine_coeff     = b_r;
  assign out_mean_radius    = mean_r;
  assign out_zero_mean_flag = zflag_r;
  assign out_last_result    = (q_r == qmax);

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input taken while word pending");
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SA) |-> (CNT_W'(i_r) < n_r)) else $error("sample index past count");
  a_zflag_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_mean_flag |-> (s_r == '0)) else $error("zero flag with nonzero sum");
`endif

endmodule

// ===== src/cfa_ram.sv =====
module cfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/cfa_qrom.sv =====
module cfa_qrom import cfa_pkg::*; (
  input  logic             clk,
  input  logic [QW_AW-1:0] addr,
  output logic [15:0]      data
);

  localparam qwave_t QWAVE = build_qwave();

  logic [15:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= QWAVE[addr];
  end

  assign data = data_r;

endmodule

// ===== src/cfa_div.sv =====
module cfa_div import cfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 qbit;

  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    qbit     = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      num_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], qbit};
      rem_nxt = qbit ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.quo  = num_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("divider done without run");
`endif

endmodule
